// ===== src/bounded_sequential_list_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BOUNDED_SEQUENTIAL_LIST_UNIT_MACROS_SVH
`define BOUNDED_SEQUENTIAL_LIST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BSLU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bslu check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define BSLU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bslu check failed");

`endif

// ===== src/bslu_pkg.sv =====
// Shared types and constants for the bounded sequential list unit.
package bslu_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_POP_BACK   = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_FIND       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Broadcast from the controller to every cell on an accepted transfer.
	typedef struct packed {
		logic                  open_slot;   // shift up from pos, write word at pos
		logic                  close_slot;  // shift down into pos and above
		logic                  find;        // compare live cells against word
		logic [IDX_W-1:0]      pos;
		logic [CNT_W-1:0]      count;       // count before the operation
		logic [DATA_WIDTH-1:0] word;
	} cell_ctl_t;

endpackage

// ===== src/bslu_cell.sv =====
// One list cell: holds a word, shifts with its neighbors, flags a find match.
module bslu_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bslu_pkg::IDX_W-1:0]      idx,
	input  bslu_pkg::cell_ctl_t             ctl,
	input  logic [bslu_pkg::DATA_WIDTH-1:0] below,
	input  logic [bslu_pkg::DATA_WIDTH-1:0] above,
	output logic [bslu_pkg::DATA_WIDTH-1:0] word,
	output logic                            match
);

	logic [bslu_pkg::DATA_WIDTH-1:0] word_q;
	logic                            match_q;
	logic                            live;

	assign live  = {1'b0, idx} < ctl.count;
	assign word  = word_q;
	assign match = match_q;

	// Storage has no reset: entries at or above the count are never read.
	always_ff @(posedge clk) begin
		if (ctl.open_slot) begin
			if (idx == ctl.pos) begin
				word_q <= ctl.word;
			end else if (idx > ctl.pos) begin
				word_q <= below;
			end
		end else if (ctl.close_slot) begin
			if (idx >= ctl.pos) begin
				word_q <= above;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctl.find && live && (word_q == ctl.word);
		end
	end

endmodule

// ===== src/bounded_sequential_list_unit.sv =====
// Top level of the bounded sequential list unit: controller and cell chain.
//
//  channel   | handshake           | payload
//  ----------+---------------------+--------------------------------------
//  command   | start / busy        | operation, position, value
//  result    | done (strobe)       | status, found_index, entry_count
//
// A command transfer takes place at a rising edge with start high and busy low.
// busy stays low: a command is taken every cycle; each cell shifts or compares
// its own word in that cycle.
// The result of a command is on the result ports in the cycle after its
// transfer, marked by done; the find result comes from the registered match
// flags in the cells and the priority encode that follows them.
// Reset clears the count, the result strobe and the match flags; the stored
// words are left as they are and are never read before they are written.
// The receiver cannot stall; each result is taken in the cycle it is shown.
module bounded_sequential_list_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          operation,
	input  logic [4:0]                          position,
	input  logic signed [31:0]                  value,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [3:0]                          found_index,
	output logic [4:0]                          entry_count
);

	localparam int CAP = bslu_pkg::CAPACITY;
	localparam int DW  = bslu_pkg::DATA_WIDTH;
	localparam int IW  = bslu_pkg::IDX_W;
	localparam int CW  = bslu_pkg::CNT_W;

	// Held count and stage-1 result registers.
	logic [CW-1:0]         count_q;
	logic                  done_s1;
	logic                  find_s1;
	bslu_pkg::status_t     status_s1;
	logic [CW-1:0]         count_s1;

	logic                  accept;
	bslu_pkg::op_t         op;
	bslu_pkg::status_t     status_d;
	logic [CW-1:0]         count_d;
	bslu_pkg::cell_ctl_t   ctl;
	logic                  do_open;
	logic                  do_close;
	logic [CW-1:0]         slot;

	logic [DW-1:0]         cell_word  [CAP];
	logic [CAP-1:0]        cell_match;

	logic [IW-1:0]         hit_idx;
	logic                  hit_any;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = bslu_pkg::op_t'(operation);

	// Decode the command against the current count. Errors leave the list alone.
	always_comb begin
		status_d = bslu_pkg::ST_OK;
		count_d  = count_q;
		do_open  = 1'b0;
		do_close = 1'b0;
		slot     = '0;
		case (op)
			bslu_pkg::OP_PUSH_BACK, bslu_pkg::OP_PUSH_FRONT: begin
				if (count_q >= CW'(CAP)) begin
					status_d = bslu_pkg::ST_FULL;
				end else begin
					do_open = 1'b1;
					slot    = (op == bslu_pkg::OP_PUSH_BACK) ? count_q : '0;
					count_d = count_q + CW'(1);
				end
			end
			bslu_pkg::OP_POP_BACK, bslu_pkg::OP_POP_FRONT: begin
				if (count_q == '0) begin
					status_d = bslu_pkg::ST_EMPTY;
				end else begin
					do_close = 1'b1;
					slot     = (op == bslu_pkg::OP_POP_BACK) ? count_q - CW'(1) : '0;
					count_d  = count_q - CW'(1);
				end
			end
			bslu_pkg::OP_INSERT: begin
				if (count_q >= CW'(CAP)) begin
					status_d = bslu_pkg::ST_FULL;
				end else if (position > count_q) begin
					status_d = bslu_pkg::ST_BADPOS;
				end else begin
					do_open = 1'b1;
					slot    = position;
					count_d = count_q + CW'(1);
				end
			end
			bslu_pkg::OP_ERASE: begin
				if (count_q == '0) begin
					status_d = bslu_pkg::ST_EMPTY;
				end else if (position >= count_q) begin
					status_d = bslu_pkg::ST_BADPOS;
				end else begin
					do_close = 1'b1;
					slot     = position;
					count_d  = count_q - CW'(1);
				end
			end
			bslu_pkg::OP_FIND: begin
				status_d = bslu_pkg::ST_NOTFOUND; // replaced by the match result
			end
			bslu_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = bslu_pkg::ST_OK;
			end
		endcase
	end

	// Broadcast to the chain; slot is below CAPACITY whenever a shift is enabled.
	always_comb begin
		ctl.open_slot  = accept && do_open;
		ctl.close_slot = accept && do_close;
		ctl.find       = accept && (op == bslu_pkg::OP_FIND);
		ctl.pos        = slot[IW-1:0];
		ctl.count      = count_q;
		ctl.word       = DW'(value);
	end

	// Row of cells; each sees its lower and upper neighbor.
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [DW-1:0] below_w;
		logic [DW-1:0] above_w;

		if (i == 0) begin : g_first
			assign below_w = '0;
		end else begin : g_mid_lo
			assign below_w = cell_word[i-1];
		end

		if (i == CAP - 1) begin : g_last
			assign above_w = '0;
		end else begin : g_mid_hi
			assign above_w = cell_word[i+1];
		end

		bslu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IW'(i)),
			.ctl    (ctl),
			.below  (below_w),
			.above  (above_w),
			.word   (cell_word[i]),
			.match  (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_s1 <= 1'b0;
			find_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				count_q <= count_d;
				find_s1 <= (op == bslu_pkg::OP_FIND);
			end
		end
	end

	// Payload of the result stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	// Lowest matching cell wins.
	always_comb begin
		hit_idx = '0;
		for (int k = CAP - 1; k >= 0; k--) begin
			if (cell_match[k]) begin
				hit_idx = IW'(k);
			end
		end
	end

	assign hit_any = |cell_match;

	// Result ports
	assign done        = done_s1;
	assign entry_count = count_s1;
	assign status      = (find_s1 && hit_any) ? bslu_pkg::ST_OK : status_s1;
	assign found_index = (find_s1 && hit_any) ? hit_idx : '0;

endmodule

// ===== src/bslu_checker.sv =====
// Port-level checker for the bounded sequential list unit, with its bind.
`include "bounded_sequential_list_unit_macros.svh"

module bslu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [3:0]  found_index,
	input logic [4:0]  entry_count
);

	// every command transfer yields a result in the next cycle
	`BSLU_ASSERT_NEXT(a_result_follows, start && !busy, done)
	// no result without a command transfer before it
	`BSLU_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done)
	// count never exceeds capacity
	`BSLU_ASSERT_NOW(a_count_bound, done, entry_count <= 5'(bslu_pkg::CAPACITY))
	// a failed operation reports index zero
	`BSLU_ASSERT_NOW(a_index_on_error, done && (status != 3'(bslu_pkg::ST_OK)), found_index == 4'd0)

endmodule

bind bounded_sequential_list_unit bslu_checker u_bslu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_index (found_index),
	.entry_count (entry_count)
);
